### rtl/grid_astar_path_finder_core_assert.svh
// Assertion macros used by the search engine of the grid path finder.
`ifndef GRID_ASTAR_PATH_FINDER_CORE_ASSERT_SVH
`define GRID_ASTAR_PATH_FINDER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define GAP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property that must hold in the cycle after a trigger.
`define GAP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define GAP_ASSERT(lbl, prop, msg)
`define GAP_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### rtl/gap_pkg.sv
// Types, constants and helper functions of the grid path finder.
package gap_pkg;

    localparam int SIDE_MAX = 8;
    localparam int COORD_W  = $clog2(SIDE_MAX);
    localparam int CELL_W   = 2 * COORD_W;
    localparam int CELLS    = SIDE_MAX * SIDE_MAX;
    localparam int CNT_W    = CELL_W + 1;
    localparam int SIZE_W   = 4;
    localparam int G_W      = 7;
    localparam int F_W      = 8;
    localparam int DIR_W    = 2;

    // Parent direction codes: the step taken from the parent into the cell.
    localparam logic [DIR_W-1:0] DIR_PX = 2'd0;
    localparam logic [DIR_W-1:0] DIR_MX = 2'd1;
    localparam logic [DIR_W-1:0] DIR_PZ = 2'd2;
    localparam logic [DIR_W-1:0] DIR_MZ = 2'd3;

    typedef enum logic [1:0] {
        OP_WALL,
        OP_SEARCH,
        OP_REJECT
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] z;
        logic               wall;
        logic [COORD_W-1:0] gx;
        logic [COORD_W-1:0] gz;
    } req_t;

    typedef struct packed {
        logic [CELL_W-1:0] loc;
        logic [G_W-1:0]    g;
    } open_ent_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_NBR,
        S_TRACE,
        S_TRACE_WAIT,
        S_EMIT_RD,
        S_EMIT_LD,
        S_NF,
        S_OUT_WAIT
    } bstate_t;

    function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [SIZE_W-1:0] size_clip(input logic [SIZE_W-1:0] s);
        size_clip = (s > SIZE_W'(SIDE_MAX)) ? SIZE_W'(SIDE_MAX) : s;
    endfunction

endpackage

### rtl/gap_front.sv
// Request queue: accepts input requests, classifies them and holds them for the engine.
module gap_front
    import gap_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [COORD_W-1:0] cell_x,
    input  logic [COORD_W-1:0] cell_z,
    input  logic               wall_flag,
    input  logic [COORD_W-1:0] goal_x,
    input  logic [COORD_W-1:0] goal_z,
    input  logic [SIZE_W-1:0]  size,
    output logic               q_valid,
    output req_t               q_req,
    input  logic               q_pop
);

    req_t       q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       in_grid;
    req_t       new_req;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = q_mem_reg[rd_ptr_reg];

    // A search whose start or goal lies outside the grid is marked as a reject here.
    assign in_grid = ({1'b0, cell_x} < size) && ({1'b0, cell_z} < size) &&
                     ({1'b0, goal_x} < size) && ({1'b0, goal_z} < size);

    always_comb
    begin
        new_req.x    = cell_x;
        new_req.z    = cell_z;
        new_req.wall = wall_flag;
        new_req.gx   = goal_x;
        new_req.gz   = goal_z;
        if (!command)
        begin
            new_req.op = OP_WALL;
        end
        else if (in_grid)
        begin
            new_req.op = OP_SEARCH;
        end
        else
        begin
            new_req.op = OP_REJECT;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (q_pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        case ({push, q_pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_req;
        end
    end

endmodule

### rtl/gap_back.sv
// Search engine: wall map, open list scan, neighbor expansion, path trace and output.
`include "grid_astar_path_finder_core_assert.svh"
module gap_back
    import gap_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [SIZE_W-1:0]  size,
    input  logic               q_valid,
    input  req_t               q_req,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COORD_W-1:0] step_x,
    output logic [COORD_W-1:0] step_z,
    output logic               path_found,
    output logic               last_step
);

    bstate_t            state_reg, state_next;
    logic [CELLS-1:0]   wall_reg, wall_next;
    logic [CELLS-1:0]   open_mark_reg, open_mark_next;
    logic [CELLS-1:0]   closed_mark_reg, closed_mark_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic               pend_reg, pend_next;
    logic [CELL_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [F_W-1:0]     best_f_reg, best_f_next;
    logic [CELL_W-1:0]  best_idx_reg, best_idx_next;
    open_ent_t          cur_reg, cur_next;
    logic [DIR_W-1:0]   dir_reg, dir_next;
    logic [CELL_W-1:0]  start_reg, start_next;
    logic [CELL_W-1:0]  goal_reg, goal_next;
    logic [CELL_W-1:0]  trace_c_reg, trace_c_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [CELL_W-1:0]  k_reg, k_next;
    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] out_x_reg, out_x_next;
    logic [COORD_W-1:0] out_z_reg, out_z_next;
    logic               out_found_reg, out_found_next;
    logic               out_last_reg, out_last_next;
    logic               search_pop;

    // Open list, parent directions and path stack memories.
    open_ent_t          ol_mem [CELLS];
    logic               ol_we;
    logic [CELL_W-1:0]  ol_waddr, ol_raddr;
    open_ent_t          ol_wdata, ol_rdata_reg;
    logic [DIR_W-1:0]   cf_mem [CELLS];
    logic               cf_we;
    logic [CELL_W-1:0]  cf_waddr, cf_raddr;
    logic [DIR_W-1:0]   cf_wdata, cf_rdata_reg;
    logic [CELL_W-1:0]  ps_mem [CELLS];
    logic               ps_we;
    logic [CELL_W-1:0]  ps_waddr, ps_raddr, ps_wdata, ps_rdata_reg;

    assign out_valid  = out_valid_reg;
    assign step_x     = out_x_reg;
    assign step_z     = out_z_reg;
    assign path_found = out_found_reg;
    assign last_step  = out_last_reg;
    assign search_pop = q_pop && (q_req.op == OP_SEARCH);

    always_comb
    begin
        logic [F_W-1:0]     f;
        logic [COORD_W-1:0] cx, cz;
        logic [SIZE_W-1:0]  nx, nz;
        logic               skip;
        logic [CELL_W-1:0]  n;
        logic [CNT_W-1:0]   cnt_n;

        state_next       = state_reg;
        wall_next        = wall_reg;
        open_mark_next   = open_mark_reg;
        closed_mark_next = closed_mark_reg;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        best_f_next      = best_f_reg;
        best_idx_next    = best_idx_reg;
        cur_next         = cur_reg;
        dir_next         = dir_reg;
        start_next       = start_reg;
        goal_next        = goal_reg;
        trace_c_next     = trace_c_reg;
        len_next         = len_reg;
        k_next           = k_reg;
        out_valid_next   = out_valid_reg;
        out_x_next       = out_x_reg;
        out_z_next       = out_z_reg;
        out_found_next   = out_found_reg;
        out_last_next    = out_last_reg;
        q_pop            = 1'b0;
        ol_we            = 1'b0;
        ol_waddr         = '0;
        ol_wdata         = '0;
        ol_raddr         = '0;
        cf_we            = 1'b0;
        cf_waddr         = '0;
        cf_wdata         = '0;
        cf_raddr         = '0;
        ps_we            = 1'b0;
        ps_waddr         = '0;
        ps_wdata         = '0;
        ps_raddr         = '0;
        f                = '0;
        cx               = cur_reg.loc[COORD_W-1:0];
        cz               = cur_reg.loc[CELL_W-1:COORD_W];
        nx               = {1'b0, cx};
        nz               = {1'b0, cz};
        skip             = 1'b0;
        n                = '0;
        cnt_n            = count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_req.op)
                        OP_WALL:
                        begin
                            wall_next[{q_req.z, q_req.x}] = q_req.wall;
                        end
                        OP_SEARCH:
                        begin
                            start_next       = {q_req.z, q_req.x};
                            goal_next        = {q_req.gz, q_req.gx};
                            open_mark_next   = '0;
                            open_mark_next[{q_req.z, q_req.x}] = 1'b1;
                            closed_mark_next = '0;
                            ol_we            = 1'b1;
                            ol_waddr         = '0;
                            ol_wdata.loc     = {q_req.z, q_req.x};
                            ol_wdata.g       = '0;
                            count_next       = CNT_W'(1);
                            ptr_next         = '0;
                            pend_next        = 1'b0;
                            best_f_next      = '1;
                            best_idx_next    = '0;
                            state_next       = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_NF;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // One open entry read per cycle; the compare uses registered data.
                if (pend_reg)
                begin
                    f = F_W'(ol_rdata_reg.g)
                        + F_W'(absdiff(ol_rdata_reg.loc[COORD_W-1:0], goal_reg[COORD_W-1:0]))
                        + F_W'(absdiff(ol_rdata_reg.loc[CELL_W-1:COORD_W],
                                       goal_reg[CELL_W-1:COORD_W]));
                    if (f < best_f_reg)
                    begin
                        best_f_next   = f;
                        best_idx_next = pend_idx_reg;
                        cur_next      = ol_rdata_reg;
                    end
                end
                if (ptr_reg < count_reg)
                begin
                    ol_raddr      = ptr_reg[CELL_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = ptr_reg[CELL_W-1:0];
                    ptr_next      = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        ptr_next   = {1'b0, best_idx_reg} + CNT_W'(1);
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                // Close the gap left by the chosen entry, keeping insertion order.
                if (pend_reg)
                begin
                    ol_we    = 1'b1;
                    ol_waddr = pend_idx_reg - CELL_W'(1);
                    ol_wdata = ol_rdata_reg;
                end
                if (ptr_reg < count_reg)
                begin
                    ol_raddr      = ptr_reg[CELL_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = ptr_reg[CELL_W-1:0];
                    ptr_next      = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next                    = count_reg - CNT_W'(1);
                        open_mark_next[cur_reg.loc]   = 1'b0;
                        closed_mark_next[cur_reg.loc] = 1'b1;
                        if (cur_reg.loc == goal_reg)
                        begin
                            trace_c_next = goal_reg;
                            len_next     = '0;
                            state_next   = S_TRACE;
                        end
                        else
                        begin
                            dir_next   = DIR_PX;
                            state_next = S_NBR;
                        end
                    end
                end
            end

            S_NBR:
            begin
                case (dir_reg)
                    DIR_PX: nx = {1'b0, cx} + SIZE_W'(1);
                    DIR_MX:
                    begin
                        skip = (cx == '0);
                        nx   = {1'b0, cx} - SIZE_W'(1);
                    end
                    DIR_PZ: nz = {1'b0, cz} + SIZE_W'(1);
                    default:
                    begin
                        skip = (cz == '0);
                        nz   = {1'b0, cz} - SIZE_W'(1);
                    end
                endcase
                n = {nz[COORD_W-1:0], nx[COORD_W-1:0]};
                if (!skip && nx < size && nz < size && !closed_mark_reg[n] &&
                    !wall_reg[n] && !open_mark_reg[n] && count_reg < CNT_W'(CELLS))
                begin
                    ol_we             = 1'b1;
                    ol_waddr          = count_reg[CELL_W-1:0];
                    ol_wdata.loc      = n;
                    ol_wdata.g        = cur_reg.g + G_W'(1);
                    cf_we             = 1'b1;
                    cf_waddr          = n;
                    cf_wdata          = dir_reg;
                    open_mark_next[n] = 1'b1;
                    cnt_n             = count_reg + CNT_W'(1);
                end
                count_next = cnt_n;
                dir_next   = dir_reg + DIR_W'(1);
                if (dir_reg == DIR_MZ)
                begin
                    if (cnt_n == '0)
                    begin
                        state_next = S_NF;
                    end
                    else
                    begin
                        ptr_next      = '0;
                        pend_next     = 1'b0;
                        best_f_next   = '1;
                        best_idx_next = '0;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_TRACE:
            begin
                ps_we    = 1'b1;
                ps_waddr = len_reg[CELL_W-1:0];
                ps_wdata = trace_c_reg;
                len_next = len_reg + CNT_W'(1);
                if (trace_c_reg == start_reg || len_reg + CNT_W'(1) == CNT_W'(CELLS))
                begin
                    k_next     = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    cf_raddr   = trace_c_reg;
                    state_next = S_TRACE_WAIT;
                end
            end

            S_TRACE_WAIT:
            begin
                case (cf_rdata_reg)
                    DIR_PX:  trace_c_next = trace_c_reg - CELL_W'(1);
                    DIR_MX:  trace_c_next = trace_c_reg + CELL_W'(1);
                    DIR_PZ:  trace_c_next = trace_c_reg - CELL_W'(SIDE_MAX);
                    default: trace_c_next = trace_c_reg + CELL_W'(SIDE_MAX);
                endcase
                state_next = S_TRACE;
            end

            S_EMIT_RD:
            begin
                ps_raddr   = len_reg[CELL_W-1:0] - CELL_W'(1) - k_reg;
                state_next = S_EMIT_LD;
            end

            S_EMIT_LD:
            begin
                out_valid_next = 1'b1;
                out_x_next     = ps_rdata_reg[COORD_W-1:0];
                out_z_next     = ps_rdata_reg[CELL_W-1:COORD_W];
                out_found_next = 1'b1;
                out_last_next  = ({1'b0, k_reg} + CNT_W'(1) == len_reg);
                state_next     = S_OUT_WAIT;
            end

            S_NF:
            begin
                out_valid_next = 1'b1;
                out_x_next     = '0;
                out_z_next     = '0;
                out_found_next = 1'b0;
                out_last_next  = 1'b1;
                state_next     = S_OUT_WAIT;
            end

            S_OUT_WAIT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + CELL_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            wall_reg        <= '0;
            open_mark_reg   <= '0;
            closed_mark_reg <= '0;
            count_reg       <= '0;
            ptr_reg         <= '0;
            pend_reg        <= 1'b0;
            dir_reg         <= '0;
            len_reg         <= '0;
            k_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            wall_reg        <= wall_next;
            open_mark_reg   <= open_mark_next;
            closed_mark_reg <= closed_mark_next;
            count_reg       <= count_next;
            ptr_reg         <= ptr_next;
            pend_reg        <= pend_next;
            dir_reg         <= dir_next;
            len_reg         <= len_next;
            k_reg           <= k_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= pend_idx_next;
        best_f_reg    <= best_f_next;
        best_idx_reg  <= best_idx_next;
        cur_reg       <= cur_next;
        start_reg     <= start_next;
        goal_reg      <= goal_next;
        trace_c_reg   <= trace_c_next;
        out_x_reg     <= out_x_next;
        out_z_reg     <= out_z_next;
        out_found_reg <= out_found_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (ol_we)
        begin
            ol_mem[ol_waddr] <= ol_wdata;
        end
        ol_rdata_reg <= ol_mem[ol_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cf_we)
        begin
            cf_mem[cf_waddr] <= cf_wdata;
        end
        cf_rdata_reg <= cf_mem[cf_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ps_we)
        begin
            ps_mem[ps_waddr] <= ps_wdata;
        end
        ps_rdata_reg <= ps_mem[ps_raddr];
    end

    `GAP_ASSERT(a_marks_disjoint, (open_mark_reg & closed_mark_reg) == '0, "cell open and closed")
    `GAP_ASSERT(a_count_bound, count_reg <= CNT_W'(CELLS), "open list overflow")
    `GAP_ASSERT(a_out_state, !out_valid_reg || state_reg == S_OUT_WAIT, "result outside wait")
    `GAP_ASSERT_NEXT(a_search_init, search_pop, count_reg == CNT_W'(1), "bad search start")
    `GAP_ASSERT_NEXT(a_search_marks, search_pop, $onehot(open_mark_reg), "bad search marks")

endmodule

### rtl/grid_astar_path_finder_core.sv
// Grid path finder top level: configuration register, request queue and search engine.
//
// A* path finder over a square grid of up to 8 x 8 cells with 4-connected unit steps
// and a Manhattan heuristic. A request with command 0 writes one wall cell and gives no
// result; a request with command 1 searches from (cell_x, cell_z) to (goal_x, goal_z)
// and returns the path start to goal, one result per cell with last_step on the final
// one, or a single not-found result. Requests pass through a two-entry queue, so the
// block can take up to two requests while the engine works or a result waits. A wall
// write is applied in the idle state. For every expanded cell, a search scans the open
// list for the minimum entry, then compacts the entries behind the chosen one (both
// through the one read port of the open list memory), then checks the four neighbors;
// there are up to 64 expansions. The path is then traced back cell by cell and sent
// cell by cell, holding each result while the receiver stalls. Configuration must be
// written only while idle.
module grid_astar_path_finder_core
    import gap_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SIZE_W-1:0]  cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic [COORD_W-1:0] cell_x,
    input  logic [COORD_W-1:0] cell_z,
    input  logic               wall_flag,
    input  logic [COORD_W-1:0] goal_x,
    input  logic [COORD_W-1:0] goal_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COORD_W-1:0] step_x,
    output logic [COORD_W-1:0] step_z,
    output logic               path_found,
    output logic               last_step
);

    logic [SIZE_W-1:0] grid_size_reg;
    logic [SIZE_W-1:0] size_use;
    logic              q_valid;
    logic              q_pop;
    req_t              q_req;

    // Grid side register; values above the largest grid act as the largest grid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= SIZE_W'(SIDE_MAX);
        end
        else if (cfg_we)
        begin
            grid_size_reg <= cfg_data;
        end
    end

    assign size_use = size_clip(grid_size_reg);

    // The front end classifies each request (wall write, search, or a search that
    // cannot succeed because an endpoint is off the grid) and queues it in order.
    gap_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .cell_x    (cell_x),
        .cell_z    (cell_z),
        .wall_flag (wall_flag),
        .goal_x    (goal_x),
        .goal_z    (goal_z),
        .size      (size_use),
        .q_valid   (q_valid),
        .q_req     (q_req),
        .q_pop     (q_pop)
    );

    // The engine owns the wall map and all search state and drives the result register.
    gap_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .size       (size_use),
        .q_valid    (q_valid),
        .q_req      (q_req),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .step_x     (step_x),
        .step_z     (step_z),
        .path_found (path_found),
        .last_step  (last_step)
    );

endmodule
